/* rtl/core/multi_led_blink_sequencer_top_defines.svh */
// assertion macros shared by the led blink sequencer modules
// no dependencies; taken in by `include where checks are written
`ifndef MULTI_LED_BLINK_SEQUENCER_TOP_DEFINES_SVH
`define MULTI_LED_BLINK_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MLBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlbs check failed");

// next-cycle implication, checked outside reset
`define MLBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlbs check failed");

`endif

/* rtl/core/mlbs_pkg.sv */
// shared types and constants of the led blink sequencer
// no dependencies; used by mlbs_front, mlbs_back and the top level
package mlbs_pkg;

    // parameter defaults and limits
    localparam int NUM_LEDS_MAX_DEF = 8;
    localparam int LED_SLOTS_MAX    = 8;   // led index field is 3 bits
    localparam int QUEUE_DEPTH      = 2;

    // request codes on the input tuser
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_BLINK = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;

    // command kinds held in the queue
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_BLINK = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W     = 1;
    localparam int         CFG_DATA_W    = 4;
    localparam logic [0:0] CFG_NUM_LEDS  = 1'b0;
    localparam logic [0:0] CFG_FINISH_EN = 1'b1;
    localparam logic [3:0] NUM_LEDS_RST  = 4'd8;

    // blink constants
    localparam logic [7:0] FOREVER_LIMIT = 8'd100;
    localparam logic [7:0] START_COUNT   = 8'hFE;

    // classified command passed from front to back
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] idx;
        logic       forever_run;
        logic [7:0] toggles;
        logic [7:0] on_time;
        logic [7:0] off_time;
    } t_cmd;

endpackage

/* rtl/core/multi_led_blink_sequencer_top.sv */
// top level of the led blink sequencer: ports, configuration registers
// depends on mlbs_pkg, mlbs_front and mlbs_back

// A blink command is carried out once it reaches the back end and the output
// register is free, and gives one result. A tick or a stop-all leaves the
// command queue, scans the LEDs in use one LED per cycle, while no held result
// waits on a stalled output, through the single read/write port of the
// per-LED state, and then closes the transaction; with num_leds at 0 it only
// leaves the queue. A toggle result is held back one step so that the last
// one can carry tlast. The front end takes items into a two-entry command
// queue while the back end works, and drops request type 3 and blink commands
// whose LED index is not below NUM_LEDS_MAX without any result.
module multi_led_blink_sequencer_top #(
    parameter int NUM_LEDS_MAX = mlbs_pkg::NUM_LEDS_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [2:0] led_index, [10:3] blink_count, [18:11] high_time, [26:19] low_time
    input  logic [31:0]                     s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                      s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] out_led, [3] led_level, [4] run_done
    output logic [7:0]                      m_axis_tdata,
    output logic                            m_axis_tlast,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mlbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mlbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [3:0]     r_num_leds;
    logic           r_finish_en;
    logic           q_valid;
    mlbs_pkg::t_cmd q_cmd;
    logic           pop;
    logic [2:0]     out_led;
    logic           led_level;
    logic           run_done;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_leds  <= mlbs_pkg::NUM_LEDS_RST;
            r_finish_en <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mlbs_pkg::CFG_NUM_LEDS:  r_num_leds  <= i_cfg_data[3:0];
                mlbs_pkg::CFG_FINISH_EN: r_finish_en <= i_cfg_data[0];
                default:                 r_num_leds  <= r_num_leds;
            endcase
        end
    end

    // front end
    mlbs_front #(
        .NUM_LEDS_MAX (NUM_LEDS_MAX)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_req_type    (s_axis_tuser),
        .i_led_index   (s_axis_tdata[2:0]),
        .i_blink_count (s_axis_tdata[10:3]),
        .i_high_time   (s_axis_tdata[18:11]),
        .i_low_time    (s_axis_tdata[26:19]),
        .o_q_valid     (q_valid),
        .o_q_cmd       (q_cmd),
        .i_pop         (pop)
    );

    // back end
    mlbs_back #(
        .NUM_LEDS_MAX (NUM_LEDS_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_num_leds  (r_num_leds),
        .i_finish_en (r_finish_en),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_out_led   (out_led),
        .o_led_level (led_level),
        .o_run_done  (run_done),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, run_done, led_level, out_led};

endmodule

/* rtl/core/mlbs_front.sv */
// front end: accepts input transactions, classifies them, queues commands
// depends on mlbs_pkg and multi_led_blink_sequencer_top_defines.svh
`include "multi_led_blink_sequencer_top_defines.svh"

module mlbs_front #(
    parameter int NUM_LEDS_MAX = mlbs_pkg::NUM_LEDS_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_req_type,
    input  logic [2:0]        i_led_index,
    input  logic [7:0]        i_blink_count,
    input  logic [7:0]        i_high_time,
    input  logic [7:0]        i_low_time,
    output logic              o_q_valid,
    output mlbs_pkg::t_cmd    o_q_cmd,
    input  logic              i_pop
);

    localparam int Q_PTR_W = (mlbs_pkg::QUEUE_DEPTH > 1) ? $clog2(mlbs_pkg::QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(mlbs_pkg::QUEUE_DEPTH + 1);

    mlbs_pkg::t_cmd r_mem [mlbs_pkg::QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    mlbs_pkg::t_cmd cmd;
    logic keep;
    logic accept;
    logic push;

    // classify: drop unused codes and blink commands past the led range
    always_comb begin
        cmd             = '0;
        cmd.idx         = i_led_index;
        cmd.on_time     = i_high_time;
        cmd.off_time    = i_low_time;
        cmd.forever_run = i_blink_count > mlbs_pkg::FOREVER_LIMIT;
        cmd.toggles     = cmd.forever_run ? 8'd0 : {i_blink_count[6:0], 1'b0};
        keep            = 1'b0;
        unique case (i_req_type)
            mlbs_pkg::REQ_TICK: begin
                cmd.kind = mlbs_pkg::KIND_TICK;
                keep     = 1'b1;
            end
            mlbs_pkg::REQ_BLINK: begin
                cmd.kind = mlbs_pkg::KIND_BLINK;
                keep     = 32'(i_led_index) < NUM_LEDS_MAX;
            end
            mlbs_pkg::REQ_STOP: begin
                cmd.kind = mlbs_pkg::KIND_STOP;
                keep     = 1'b1;
            end
            default: begin
                cmd.kind = mlbs_pkg::KIND_TICK;
                keep     = 1'b0;
            end
        endcase
    end

    assign o_ready   = r_count != Q_CNT_W'(mlbs_pkg::QUEUE_DEPTH);
    assign accept    = i_valid && o_ready;
    assign push      = accept && keep;
    assign o_q_valid = r_count != '0;
    assign o_q_cmd   = r_mem[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cmd;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= Q_PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= Q_PTR_W'(r_rd_ptr + 1'b1);
            end
            if (push && !i_pop) begin
                r_count <= Q_CNT_W'(r_count + 1'b1);
            end else if (!push && i_pop) begin
                r_count <= Q_CNT_W'(r_count - 1'b1);
            end
        end
    end

    // checks
    `MLBS_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_count <= Q_CNT_W'(mlbs_pkg::QUEUE_DEPTH))
    `MLBS_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)
    `MLBS_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push && !i_pop, r_count == Q_CNT_W'($past(r_count) + 1'b1))

endmodule

/* rtl/core/mlbs_back.sv */
// back end: per-led blink state, led scan sequencer and output register
// depends on mlbs_pkg and multi_led_blink_sequencer_top_defines.svh
`include "multi_led_blink_sequencer_top_defines.svh"

module mlbs_back #(
    parameter int NUM_LEDS_MAX = mlbs_pkg::NUM_LEDS_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3:0]        i_num_leds,
    input  logic              i_finish_en,
    input  logic              i_q_valid,
    input  mlbs_pkg::t_cmd    i_q_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_out_led,
    output logic              o_led_level,
    output logic              o_run_done,
    output logic              o_last
);

    localparam int LED_CNT   = (NUM_LEDS_MAX < mlbs_pkg::LED_SLOTS_MAX) ?
                               NUM_LEDS_MAX : mlbs_pkg::LED_SLOTS_MAX;
    localparam int LED_IDX_W = (LED_CNT > 1) ? $clog2(LED_CNT) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // per-led state
    logic       r_level   [LED_CNT];
    logic [7:0] r_edge    [LED_CNT];
    logic [7:0] r_toggles [LED_CNT];
    logic       r_forever [LED_CNT];
    logic [7:0] r_on      [LED_CNT];
    logic [7:0] r_off     [LED_CNT];

    // sequencer
    logic [1:0]           r_state, n_state;
    logic [LED_IDX_W-1:0] r_idx, n_idx;
    logic                 r_is_stop, n_is_stop;
    logic                 r_hold_vld, n_hold_vld;
    logic [2:0]           r_hold_led, n_hold_led;
    logic                 r_hold_lvl, n_hold_lvl;
    logic                 r_hold_done, n_hold_done;

    // output register
    logic       r_out_vld;
    logic [2:0] r_out_led;
    logic       r_out_lvl;
    logic       r_out_done;
    logic       r_out_last;

    logic [3:0]           scan_n;
    logic                 out_free;
    logic                 step_ok;
    logic                 last_step;
    logic                 cur_level;
    logic [7:0]           cur_edge;
    logic [7:0]           cur_toggles;
    logic                 cur_forever;
    logic                 active;
    logic [7:0]           edge_inc;
    logic [7:0]           limit;
    logic                 hit;
    logic                 res;
    logic                 res_lvl;
    logic                 res_done;
    logic                 blink_load;

    logic                 wr_en;
    logic                 wr_times;
    logic [LED_IDX_W-1:0] wr_idx;
    logic                 wr_level;
    logic [7:0]           wr_edge;
    logic [7:0]           wr_toggles;
    logic                 wr_forever;

    logic                 out_load;
    logic [2:0]           out_led;
    logic                 out_lvl;
    logic                 out_done;
    logic                 out_last;

    assign scan_n    = (i_num_leds > 4'(LED_CNT)) ? 4'(LED_CNT) : i_num_leds;
    assign out_free  = !r_out_vld || i_ready;
    assign step_ok   = !r_hold_vld || out_free;
    assign last_step = (4'(r_idx) + 4'd1) == scan_n;

    // state of the led under scan
    assign cur_level   = r_level[r_idx];
    assign cur_edge    = r_edge[r_idx];
    assign cur_toggles = r_toggles[r_idx];
    assign cur_forever = r_forever[r_idx];
    assign active      = cur_forever || (cur_toggles != 8'd0);
    assign edge_inc    = 8'(cur_edge + 1'b1);
    assign limit       = cur_level ? r_on[r_idx] : r_off[r_idx];
    assign hit         = edge_inc > limit;

    // sequencer next state, state writes and result selection
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_is_stop   = r_is_stop;
        n_hold_vld  = r_hold_vld;
        n_hold_led  = r_hold_led;
        n_hold_lvl  = r_hold_lvl;
        n_hold_done = r_hold_done;
        o_pop       = 1'b0;
        blink_load  = 1'b0;
        wr_en       = 1'b0;
        wr_times    = 1'b0;
        wr_idx      = r_idx;
        wr_level    = cur_level;
        wr_edge     = cur_edge;
        wr_toggles  = cur_toggles;
        wr_forever  = cur_forever;
        res         = 1'b0;
        res_lvl     = 1'b0;
        res_done    = 1'b0;
        out_load    = 1'b0;
        out_led     = r_hold_led;
        out_lvl     = r_hold_lvl;
        out_done    = r_hold_done;
        out_last    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_cmd.kind == mlbs_pkg::KIND_BLINK) begin
                        // load one led and report it off
                        if (out_free) begin
                            o_pop      = 1'b1;
                            blink_load = 1'b1;
                            wr_en      = 1'b1;
                            wr_times   = 1'b1;
                            wr_idx     = i_q_cmd.idx[LED_IDX_W-1:0];
                            wr_level   = 1'b0;
                            wr_edge    = mlbs_pkg::START_COUNT;
                            wr_toggles = i_q_cmd.toggles;
                            wr_forever = i_q_cmd.forever_run;
                            out_load   = 1'b1;
                            out_led    = i_q_cmd.idx;
                            out_lvl    = 1'b0;
                            out_done   = 1'b0;
                            out_last   = 1'b1;
                        end
                    end else begin
                        o_pop     = 1'b1;
                        n_idx     = '0;
                        n_is_stop = i_q_cmd.kind == mlbs_pkg::KIND_STOP;
                        if (scan_n != 4'd0) begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (step_ok) begin
                    wr_en = 1'b1;
                    if (r_is_stop) begin
                        wr_level   = 1'b0;
                        wr_edge    = 8'd0;
                        wr_toggles = 8'd0;
                        wr_forever = 1'b0;
                        res        = 1'b1;
                    end else if (active) begin
                        if (hit) begin
                            wr_edge  = 8'd1;
                            wr_level = !cur_level;
                            if (!cur_forever) begin
                                wr_toggles = 8'(cur_toggles - 1'b1);
                            end
                            res      = 1'b1;
                            res_lvl  = !cur_level;
                            res_done = !cur_forever && (cur_toggles == 8'd1) && i_finish_en;
                        end else begin
                            wr_edge = edge_inc;
                        end
                    end
                    // a new result pushes the held one out, not yet the last
                    if (res) begin
                        n_hold_vld  = 1'b1;
                        n_hold_led  = 3'(r_idx);
                        n_hold_lvl  = res_lvl;
                        n_hold_done = res_done;
                        if (r_hold_vld) begin
                            out_load = 1'b1;
                        end
                    end
                    if (last_step) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx = LED_IDX_W'(r_idx + 1'b1);
                    end
                end
            end
            ST_FLUSH: begin
                // the held result closes the transaction
                if (!r_hold_vld) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    n_hold_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // per-led state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LED_CNT; i++) begin
                r_level[i]   <= 1'b0;
                r_edge[i]    <= 8'd0;
                r_toggles[i] <= 8'd0;
                r_forever[i] <= 1'b0;
                r_on[i]      <= 8'd0;
                r_off[i]     <= 8'd0;
            end
        end else if (wr_en) begin
            r_level[wr_idx]   <= wr_level;
            r_edge[wr_idx]    <= wr_edge;
            r_toggles[wr_idx] <= wr_toggles;
            r_forever[wr_idx] <= wr_forever;
            if (wr_times) begin
                r_on[wr_idx]  <= i_q_cmd.on_time;
                r_off[wr_idx] <= i_q_cmd.off_time;
            end
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_is_stop  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_is_stop  <= n_is_stop;
            r_hold_vld <= n_hold_vld;
        end
    end

    // held result payload
    always_ff @(posedge i_clk) begin
        r_hold_led  <= n_hold_led;
        r_hold_lvl  <= n_hold_lvl;
        r_hold_done <= n_hold_done;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_led  <= out_led;
            r_out_lvl  <= out_lvl;
            r_out_done <= out_done;
            r_out_last <= out_last;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_out_led   = r_out_led;
    assign o_led_level = r_out_lvl;
    assign o_run_done  = r_out_done;
    assign o_last      = r_out_last;

    // checks
    `MLBS_ASSERT_IMPL(a_hold_busy, i_clk, i_rst_n, r_hold_vld, r_state != ST_IDLE)
    `MLBS_ASSERT_IMPL(a_scan_range, i_clk, i_rst_n, r_state == ST_SCAN, 4'(r_idx) < scan_n)
    `MLBS_ASSERT_NEXT(a_blink_last, i_clk, i_rst_n, blink_load, r_out_vld && r_out_last)

endmodule

/* tb/tb_multi_led_blink_sequencer_top.sv */
// self-checking testbench for multi_led_blink_sequencer_top: directed and random streams
// depends on mlbs_pkg and the multi_led_blink_sequencer_top rtl
module tb_multi_led_blink_sequencer_top;

    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         LED_COUNT     = mlbs_pkg::NUM_LEDS_MAX_DEF;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         MAX_REPORTS   = 30;

    // one led level update as seen on the result stream
    typedef struct {
        logic [2:0] led;
        logic       level;
        logic       done;
        logic       last;
    } t_led_update;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [mlbs_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [mlbs_pkg::CFG_DATA_W-1:0] i_cfg_data;

    multi_led_blink_sequencer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // updates still owed by the block, oldest first
    t_led_update expected_updates[$];

    // predicted per-led state and register copies
    logic       led_level_q [LED_COUNT];
    logic [7:0] edge_cnt_q  [LED_COUNT];
    logic [7:0] toggles_q   [LED_COUNT];
    logic       forever_q   [LED_COUNT];
    logic [7:0] on_ticks_q  [LED_COUNT];
    logic [7:0] off_ticks_q [LED_COUNT];
    logic [3:0] leds_in_use_q;
    logic       finish_en_q;

    // idling controls and run statistics
    bit tx_gaps_on     = 1'b1;
    bit rx_gaps_on     = 1'b1;
    int rx_hold_cycles = 0;
    int mismatch_count = 0;
    int updates_checked = 0;
    int n_ticks   = 0;
    int n_blinks  = 0;
    int n_stops   = 0;
    int n_unused  = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("timeout waiting for led updates");
        $display("status: fail");
        $finish;
    end

    // works out the led updates one accepted request causes
    function automatic void predict_led_updates(logic [1:0] req, logic [2:0] idx,
                                                logic [7:0] cnt, logic [7:0] hi,
                                                logic [7:0] lo);
        t_led_update batch[$];
        t_led_update upd;
        int          scan;
        logic [7:0]  limit;
        scan = (leds_in_use_q > LED_COUNT) ? LED_COUNT : int'(leds_in_use_q);
        upd.last = 1'b0;
        upd.done = 1'b0;
        case (req)
            mlbs_pkg::REQ_BLINK: begin
                led_level_q[idx] = 1'b0;
                edge_cnt_q[idx]  = mlbs_pkg::START_COUNT;
                if (cnt > mlbs_pkg::FOREVER_LIMIT) begin
                    forever_q[idx] = 1'b1;
                    toggles_q[idx] = 8'd0;
                end else begin
                    forever_q[idx] = 1'b0;
                    toggles_q[idx] = cnt * 8'd2;
                end
                on_ticks_q[idx]  = hi;
                off_ticks_q[idx] = lo;
                upd.led   = idx;
                upd.level = 1'b0;
                batch.push_back(upd);
            end
            mlbs_pkg::REQ_TICK: begin
                for (int i = 0; i < scan; i++) begin
                    if (forever_q[i] || toggles_q[i] != 8'd0) begin
                        edge_cnt_q[i] = edge_cnt_q[i] + 8'd1;
                        limit = led_level_q[i] ? on_ticks_q[i] : off_ticks_q[i];
                        if (edge_cnt_q[i] > limit) begin
                            edge_cnt_q[i]  = 8'd1;
                            led_level_q[i] = ~led_level_q[i];
                            upd.done = 1'b0;
                            // finite runs count down and may flag completion
                            if (!forever_q[i]) begin
                                toggles_q[i] = toggles_q[i] - 8'd1;
                                if (toggles_q[i] == 8'd0 && finish_en_q)
                                    upd.done = 1'b1;
                            end
                            upd.led   = 3'(i);
                            upd.level = led_level_q[i];
                            batch.push_back(upd);
                        end
                    end
                end
            end
            mlbs_pkg::REQ_STOP: begin
                // on and off times survive a stop-all
                for (int i = 0; i < scan; i++) begin
                    led_level_q[i] = 1'b0;
                    edge_cnt_q[i]  = 8'd0;
                    toggles_q[i]   = 8'd0;
                    forever_q[i]   = 1'b0;
                    upd.led   = 3'(i);
                    upd.level = 1'b0;
                    upd.done  = 1'b0;
                    batch.push_back(upd);
                end
            end
            default: ;
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            expected_updates.push_back(batch[k]);
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // compares one accepted update with the oldest expectation
    task automatic check_update();
        t_led_update want;
        updates_checked++;
        if (expected_updates.size() == 0) begin
            report_mismatch("update with none expected", m_axis_tdata, 8'hFF);
            return;
        end
        want = expected_updates.pop_front();
        if (m_axis_tdata[2:0] !== want.led)
            report_mismatch("out_led", 8'(m_axis_tdata[2:0]), 8'(want.led));
        if (m_axis_tdata[3] !== want.level)
            report_mismatch("led_level", 8'(m_axis_tdata[3]), 8'(want.level));
        if (m_axis_tdata[4] !== want.done)
            report_mismatch("run_done", 8'(m_axis_tdata[4]), 8'(want.done));
        if (m_axis_tlast !== want.last)
            report_mismatch("tlast", 8'(m_axis_tlast), 8'(want.last));
    endtask

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_update();
    end

    // result receiver: random stall bursts and requested long hold-offs
    initial begin : result_receiver
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 8) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // offers one request and waits until it is accepted
    task automatic send_request(logic [1:0] req, logic [2:0] idx, logic [7:0] cnt,
                                logic [7:0] hi, logic [7:0] lo);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {5'd0, lo, hi, cnt, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_led_updates(req, idx, cnt, hi, lo);
        case (req)
            mlbs_pkg::REQ_TICK:  n_ticks++;
            mlbs_pkg::REQ_BLINK: n_blinks++;
            mlbs_pkg::REQ_STOP:  n_stops++;
            default:             n_unused++;
        endcase
    endtask

    // stops offering, waits for every owed update and lets the block settle
    task automatic wait_for_quiet();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_updates.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register write, only once the block is idle
    task automatic write_register(logic [mlbs_pkg::CFG_IDX_W-1:0] reg_index,
                                  logic [mlbs_pkg::CFG_DATA_W-1:0] value);
        wait_for_quiet();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (reg_index == mlbs_pkg::CFG_NUM_LEDS)
            leds_in_use_q = value;
        else
            finish_en_q = value[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random stream: mostly programmed leds followed by runs of ticks
    task automatic run_random_items(int quota);
        int         sent;
        int         pick;
        int         span;
        logic [7:0] blink_cnt;
        sent = 0;
        span = (leds_in_use_q == 0) ? 1 :
               (leds_in_use_q > LED_COUNT) ? LED_COUNT : int'(leds_in_use_q);
        while (sent < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                repeat ($urandom_range(1, 3)) begin
                    blink_cnt = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(101, 255))
                                                            : 8'($urandom_range(0, 5));
                    send_request(mlbs_pkg::REQ_BLINK, 3'($urandom_range(0, span - 1)),
                                 blink_cnt, 8'($urandom_range(0, 3)),
                                 8'($urandom_range(0, 3)));
                    sent++;
                end
                repeat ($urandom_range(3, 12)) begin
                    send_request(mlbs_pkg::REQ_TICK, 3'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom));
                    sent++;
                end
            end else if (pick < 85) begin
                send_request(mlbs_pkg::REQ_BLINK, 3'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom));
                sent++;
            end else if (pick < 92) begin
                send_request(mlbs_pkg::REQ_STOP, 3'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom));
                sent++;
            end else if (pick < 96) begin
                // ignored by the block, not counted
                send_request(REQ_UNUSED, 3'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
            end else begin
                send_request(mlbs_pkg::REQ_TICK, 3'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    // reset setting: extremes of the fields, forever runs, stuck levels
    task automatic test_blink_basics();
        send_request(mlbs_pkg::REQ_BLINK, 3'd0, 8'd1, 8'd0, 8'd0);
        send_request(mlbs_pkg::REQ_BLINK, 3'd7, 8'd255, 8'd255, 8'd255);
        send_request(mlbs_pkg::REQ_BLINK, 3'd3, 8'd0, 8'd5, 8'd5);
        send_request(mlbs_pkg::REQ_BLINK, 3'd5, 8'd101, 8'd1, 8'd0);
        send_request(mlbs_pkg::REQ_BLINK, 3'd2, 8'd100, 8'd0, 8'd3);
        repeat (4) send_request(mlbs_pkg::REQ_TICK, 3'd0, 8'd0, 8'd0, 8'd0);
        send_request(REQ_UNUSED, 3'd7, 8'd255, 8'd255, 8'd255);
        send_request(mlbs_pkg::REQ_TICK, 3'd7, 8'd255, 8'd255, 8'd255);
        send_request(mlbs_pkg::REQ_STOP, 3'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // completion flag, and a command for an led outside the scanned range
    task automatic test_run_completion();
        write_register(mlbs_pkg::CFG_FINISH_EN, 4'd1);
        write_register(mlbs_pkg::CFG_NUM_LEDS, 4'd3);
        send_request(mlbs_pkg::REQ_BLINK, 3'd1, 8'd2, 8'd0, 8'd1);
        send_request(mlbs_pkg::REQ_BLINK, 3'd6, 8'd100, 8'd0, 8'd0);
        repeat (5) send_request(mlbs_pkg::REQ_TICK, 3'd0, 8'd0, 8'd0, 8'd0);
        send_request(mlbs_pkg::REQ_STOP, 3'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // no leds scanned, then a count above the led limit
    task automatic test_led_count_extremes();
        write_register(mlbs_pkg::CFG_NUM_LEDS, 4'd0);
        send_request(mlbs_pkg::REQ_BLINK, 3'd4, 8'd3, 8'd0, 8'd0);
        send_request(mlbs_pkg::REQ_TICK, 3'd0, 8'd0, 8'd0, 8'd0);
        send_request(mlbs_pkg::REQ_STOP, 3'd0, 8'd0, 8'd0, 8'd0);
        write_register(mlbs_pkg::CFG_NUM_LEDS, 4'd15);
        send_request(mlbs_pkg::REQ_TICK, 3'd0, 8'd0, 8'd0, 8'd0);
        send_request(mlbs_pkg::REQ_STOP, 3'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // random streams under several register settings
    task automatic test_random_patterns();
        logic [3:0] phase_leds   [4];
        logic       phase_finish [4];
        phase_leds   = '{4'd8, 4'd1, 4'd15, 4'($urandom_range(2, 7))};
        phase_finish = '{1'b1, 1'b0, 1'b1, 1'($urandom)};
        for (int p = 0; p < 4; p++) begin
            write_register(mlbs_pkg::CFG_NUM_LEDS, phase_leds[p]);
            write_register(mlbs_pkg::CFG_FINISH_EN, {3'd0, phase_finish[p]});
            run_random_items(40);
        end
    endtask

    // long receiver hold-off with every led toggling on each tick
    task automatic test_output_backpressure();
        write_register(mlbs_pkg::CFG_NUM_LEDS, 4'd8);
        write_register(mlbs_pkg::CFG_FINISH_EN, 4'd1);
        for (int i = 0; i < LED_COUNT; i++)
            send_request(mlbs_pkg::REQ_BLINK, 3'(i), 8'd200, 8'd0, 8'd0);
        rx_hold_cycles = 150;
        repeat (20) send_request(mlbs_pkg::REQ_TICK, 3'd0, 8'd0, 8'd0, 8'd0);
        // sender pauses until every owed update is out
        wait_for_quiet();
        repeat (6) send_request(mlbs_pkg::REQ_TICK, 3'd0, 8'd0, 8'd0, 8'd0);
        send_request(mlbs_pkg::REQ_STOP, 3'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // closing stretch with both sides at full rate
    task automatic test_full_rate();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        write_register(mlbs_pkg::CFG_NUM_LEDS, 4'd6);
        write_register(mlbs_pkg::CFG_FINISH_EN, 4'd0);
        run_random_items(40);
    endtask

    // test sequence
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        foreach (led_level_q[i]) begin
            led_level_q[i] = 1'b0;
            edge_cnt_q[i]  = 8'd0;
            toggles_q[i]   = 8'd0;
            forever_q[i]   = 1'b0;
            on_ticks_q[i]  = 8'd0;
            off_ticks_q[i] = 8'd0;
        end
        leds_in_use_q = mlbs_pkg::NUM_LEDS_RST;
        finish_en_q   = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_blink_basics();
        test_run_completion();
        test_led_count_extremes();
        test_random_patterns();
        test_output_backpressure();
        test_full_rate();
        wait_for_quiet();

        $display("covered %0d ticks, %0d blink commands, %0d stop-all, %0d unused codes",
                 n_ticks, n_blinks, n_stops, n_unused);
        $display("led counts 0 to 15 with completion on and off: %0d updates, %0d mismatches",
                 updates_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
